// ===== src/bisb_pkg.sv =====
// Shared constants, types and helpers for the byte init shadow bitmap core.
// No dependencies; imported by every module of the block.
package bisb_pkg;

    localparam int MAX_BYTES_DEF = 4096;
    localparam int ADDR_W        = 32;
    localparam int SIZE_W        = 13;
    localparam int WORD_W        = SIZE_W - 3;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
    localparam logic [7:0]        MARKS_ALL  = 8'hff;

    localparam logic ACT_MARK  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_SIZE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [SIZE_W-1:0] obj_len;
    } t_cfg;

    // bytes first..last-1 of a word, byte 0 in the MSB
    function automatic logic [7:0] span_mask(input logic [2:0] first, input logic [3:0] last);
        logic [3:0] sh;
        sh = 4'd8 - last;
        return (MARKS_ALL >> first) & (MARKS_ALL << sh);
    endfunction

endpackage

// ===== src/byte_init_shadow_bitmap_core.sv =====
// Top level of the byte init shadow bitmap core: range classification,
// word walk sequencer and output register. Depends on bisb_pkg, bisb_cfg, bisb_mem.
//
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_ready  | i_action, i_begin_address, i_end_address
//   result  | out       | o_valid / i_ready  | o_initialized, o_range_error
//   config  | in        | psel/penable/pready| pwrite, paddr, pwdata, prdata
//
// An in-object range is walked through the read port one bitmap word per cycle;
// other items skip the walk and go to the result stage.
// After reset a clearing pass sets all (MAX_BYTES+7)/8 words, one per cycle
// (512 at the default), with o_ready low; register writes are taken meanwhile.
// One item is in flight at a time; a pending result holds until taken.
module byte_init_shadow_bitmap_core
    import bisb_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic [ADDR_W-1:0]  i_begin_address,
    input  logic [ADDR_W-1:0]  i_end_address,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_initialized,
    output logic               o_range_error,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int MarkWords = (MAX_BYTES + 7) / 8;
    localparam int Aw        = (MarkWords > 1) ? $clog2(MarkWords) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    t_cfg cfg;

    logic [2:0]        r_state, n_state;
    logic [Aw-1:0]     r_clr, n_clr;
    logic              r_action, n_action;
    logic [WORD_W-1:0] r_w, n_w;
    logic [WORD_W-1:0] r_wl, n_wl;
    logic [WORD_W-1:0] r_wh, n_wh;
    logic [2:0]        r_lo3, n_lo3;
    logic [2:0]        r_hl3, n_hl3;
    logic              r_p_valid, n_p_valid;
    logic [Aw-1:0]     r_p_w, n_p_w;
    logic              r_p_first, n_p_first;
    logic              r_p_last, n_p_last;
    logic              r_init, n_init;
    logic              r_err, n_err;
    logic              r_o_valid, n_o_valid;
    logic              r_o_init, n_o_init;
    logic              r_o_err, n_o_err;

    logic [SIZE_W-1:0] eff_size;
    logic [ADDR_W:0]   limit;
    logic              is_empty, is_reversed, is_outside;
    logic [ADDR_W-1:0] off_lo, off_hi1;

    logic              mem_we, mem_re;
    logic [Aw-1:0]     mem_waddr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic [2:0]        m_first;
    logic [3:0]        m_last;
    logic [7:0]        m_span;
    logic              in_beat, out_free;

    bisb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bisb_mem #(
        .DEPTH (MarkWords),
        .AW    (Aw)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (Aw'(r_w)),
        .o_rdata (mem_rdata)
    );

    assign eff_size = ({{(ADDR_W-SIZE_W){1'b0}}, cfg.obj_len} > ADDR_W'(MAX_BYTES))
                    ? SIZE_W'(MAX_BYTES) : cfg.obj_len;
    assign limit       = {1'b0, cfg.base_address} + (ADDR_W+1)'(eff_size);
    assign is_empty    = i_begin_address == i_end_address;
    assign is_reversed = i_begin_address > i_end_address;
    assign is_outside  = (i_begin_address < cfg.base_address)
                      || ({1'b0, i_end_address} > limit);
    assign off_lo      = i_begin_address - cfg.base_address;
    assign off_hi1     = i_end_address - cfg.base_address - ADDR_W'(1);

    assign m_first = r_p_first ? r_lo3 : 3'd0;
    assign m_last  = r_p_last ? ({1'b0, r_hl3} + 4'd1) : 4'd8;
    assign m_span  = span_mask(m_first, m_last);

    assign o_ready  = r_state == ST_IDLE;
    assign in_beat  = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    assign mem_re    = r_state == ST_RUN;
    assign mem_we    = (r_state == ST_CLEAR) || (r_p_valid && (r_action == ACT_MARK));
    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr : r_p_w;
    assign mem_wdata = (r_state == ST_CLEAR) ? MARKS_ALL : (mem_rdata & ~m_span);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_action  = r_action;
        n_w       = r_w;
        n_wl      = r_wl;
        n_wh      = r_wh;
        n_lo3     = r_lo3;
        n_hl3     = r_hl3;
        n_p_valid = 1'b0;
        n_p_w     = r_p_w;
        n_p_first = r_p_first;
        n_p_last  = r_p_last;
        n_init    = r_init;
        n_err     = r_err;
        n_o_valid = r_o_valid && !i_ready;
        n_o_init  = r_o_init;
        n_o_err   = r_o_err;

        if (r_p_valid && (r_action == ACT_QUERY) && ((mem_rdata & m_span) != 8'h00)) begin
            n_init = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + Aw'(1);
                if (r_clr == Aw'(MarkWords - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_beat) begin
                    n_action = i_action;
                    n_wl     = off_lo[SIZE_W-1:3];
                    n_w      = off_lo[SIZE_W-1:3];
                    n_wh     = off_hi1[SIZE_W-1:3];
                    n_lo3    = off_lo[2:0];
                    n_hl3    = off_hi1[2:0];
                    n_init   = 1'b1;
                    n_err    = 1'b0;
                    n_state  = ST_DONE;
                    priority if (is_empty) begin
                    end else if (is_reversed) begin
                        n_init = i_action == ACT_MARK;
                    end else if (is_outside) begin
                        n_init = 1'b0;
                        n_err  = 1'b1;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                n_p_valid = 1'b1;
                n_p_w     = Aw'(r_w);
                n_p_first = r_w == r_wl;
                n_p_last  = r_w == r_wh;
                if (r_w == r_wh) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_w = r_w + WORD_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_init  = r_init;
                    n_o_err   = r_err;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_w       <= n_w;
        r_wl      <= n_wl;
        r_wh      <= n_wh;
        r_lo3     <= n_lo3;
        r_hl3     <= n_hl3;
        r_p_w     <= n_p_w;
        r_p_first <= n_p_first;
        r_p_last  <= n_p_last;
        r_init    <= n_init;
        r_err     <= n_err;
        r_o_init  <= n_o_init;
        r_o_err   <= n_o_err;
    end

    assign o_valid       = r_o_valid;
    assign o_initialized = r_o_init;
    assign o_range_error = r_o_err;

`ifndef SYNTHESIS
    a_err_not_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_err |-> !r_o_init)
        else $error("range error reported with initialized set");

    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_CLEAR) || (r_p_valid && r_action == ACT_MARK))
        else $error("bitmap write outside clearing pass or mark walk");

    a_no_read_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && mem_re |-> mem_waddr != Aw'(r_w))
        else $error("read and write of the same bitmap word in one cycle");

    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |-> r_p_valid && r_p_last)
        else $error("walk drained without its last word in flight");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state) == ST_CLEAR && r_state == ST_CLEAR |-> !r_p_valid && !r_o_valid)
        else $error("activity during clearing pass");
`endif

endmodule

// ===== src/bisb_cfg.sv =====
// APB-style register bank: object base address and object size.
// Depends on bisb_pkg.
module bisb_cfg
    import bisb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_size;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_size <= SIZE_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_BASE: r_base <= pwdata;
                REG_SIZE: r_size <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_BASE: prdata = r_base;
            REG_SIZE: prdata = {{(PDATA_W-SIZE_W){1'b0}}, r_size};
            default:  prdata = '0;
        endcase
    end

    assign o_cfg.base_address = r_base;
    assign o_cfg.obj_len      = r_size;

endmodule

// ===== src/bisb_mem.sv =====
// Mark bitmap storage: one write port, one read port, registered read data.
// Depends on bisb_pkg.
module bisb_mem
    import bisb_pkg::*;
#(
    parameter int DEPTH = (MAX_BYTES_DEF + 7) / 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/shadow_bitmap_check.sv =====
// Scoreboard for the byte init shadow bitmap core: watches the request, result and
// register channels, predicts every result from its own copy of the bitmap and
// compares it field by field. Depends on bisb_pkg.
module shadow_bitmap_check
    import bisb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic               i_action,
    input  logic [ADDR_W-1:0]  i_begin_address,
    input  logic [ADDR_W-1:0]  i_end_address,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic               i_initialized,
    input  logic               i_range_error,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_fail_count,
    output int                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MARK_WORDS = (MAX_BYTES_DEF + 7) / 8;
    localparam logic [PADDR_W-1:0] BASE_ADDR = {REG_BASE, 2'b00};
    localparam logic [PADDR_W-1:0] SIZE_ADDR = {REG_SIZE, 2'b00};

    typedef struct packed {
        logic initialized;
        logic range_error;
    } t_range_reply;

    logic [7:0]        shadow_marks [MARK_WORDS];
    logic [ADDR_W-1:0] object_base;
    logic [SIZE_W-1:0] obj_len;
    t_range_reply      pending_replies [$];

    function automatic t_range_reply predict_range_reply(input logic act,
                                                         input logic [ADDR_W-1:0] b,
                                                         input logic [ADDR_W-1:0] e);
        t_range_reply      r;
        logic [SIZE_W-1:0] eff;
        logic [ADDR_W:0]   limit;
        logic [7:0]        m;
        int unsigned       lo, hi, wl, wh, w, first, last;
        r.initialized = 1'b0;
        r.range_error = 1'b0;
        eff = (obj_len > MAX_BYTES_DEF) ? SIZE_W'(MAX_BYTES_DEF) : obj_len;
        limit = {1'b0, object_base} + eff;
        if (b == e) begin
            r.initialized = 1'b1;
        end else if (b > e) begin
            r.initialized = (act == ACT_MARK);
        end else if (b < object_base || {1'b0, e} > limit) begin
            r.range_error = 1'b1;
        end else begin
            r.initialized = 1'b1;
            lo = b - object_base;
            hi = e - object_base;
            wl = lo / 8;
            wh = (hi - 1) / 8;
            for (w = wl; w <= wh && w < MARK_WORDS; w++) begin
                first = (w == wl) ? lo % 8 : 0;
                last  = (w == wh) ? hi - 8 * w : 8;
                m = (8'hff >> first) & (8'hff << (8 - last));
                if (act == ACT_MARK)
                    shadow_marks[w] = shadow_marks[w] & ~m;
                else if ((shadow_marks[w] & m) != 8'h00)
                    r.initialized = 1'b0;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_range_reply want;
        if (!i_rst_n) begin
            foreach (shadow_marks[k])
                shadow_marks[k] = MARKS_ALL;
            object_base = '0;
            obj_len = SIZE_RESET;
            pending_replies.delete();
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == BASE_ADDR)
                    object_base = i_pwdata[ADDR_W-1:0];
                else if (i_paddr == SIZE_ADDR)
                    obj_len = i_pwdata[SIZE_W-1:0];
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding, initialized %0b range_error %0b",
                             $time, i_initialized, i_range_error);
                    o_fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (i_initialized !== want.initialized) begin
                        $display("%0t: initialized expected %0b, actual %0b",
                                 $time, want.initialized, i_initialized);
                        o_fail_count++;
                    end
                    if (i_range_error !== want.range_error) begin
                        $display("%0t: range_error expected %0b, actual %0b",
                                 $time, want.range_error, i_range_error);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                pending_replies.push_back(predict_range_reply(i_action, i_begin_address,
                                                              i_end_address));
        end
        o_outstanding = pending_replies.size();
    end

endmodule

// ===== verif/byte_init_shadow_bitmap_core_test.sv =====
// Top of the byte init shadow bitmap core testbench: clock, reset, register writes,
// range requests and result back-pressure, plus the verdict.
// Depends on bisb_pkg, byte_init_shadow_bitmap_core and shadow_bitmap_check.
module byte_init_shadow_bitmap_core_test
    import bisb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 520;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_action = ACT_MARK;
    logic [ADDR_W-1:0]  i_begin_address = '0;
    logic [ADDR_W-1:0]  i_end_address = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_initialized;
    logic               o_range_error;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 fail_count;
    int                 outstanding;
    int                 quiet_cycles = 0;
    bit                 steady_send = 1'b0;
    bit                 steady_take = 1'b0;
    bit                 hold_request = 1'b0;
    bit                 hold_taken = 1'b0;
    logic [ADDR_W-1:0]  cur_base = '0;
    logic [SIZE_W-1:0]  cur_size = SIZE_RESET;

    byte_init_shadow_bitmap_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_begin_address (i_begin_address),
        .i_end_address   (i_end_address),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_initialized   (o_initialized),
        .o_range_error   (o_range_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    shadow_bitmap_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_action        (i_action),
        .i_begin_address (i_begin_address),
        .i_end_address   (i_end_address),
        .i_rsp_valid     (o_valid),
        .i_rsp_ready     (i_ready),
        .i_initialized   (o_initialized),
        .i_range_error   (o_range_error),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready <= steady_take || ($urandom_range(99) >= 16);
        end
    end

    task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    task automatic set_object(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size);
        logic [PDATA_W-1:0] size_word;
        i_valid <= 1'b0;
        drain_results();
        size_word = $urandom;
        size_word[SIZE_W-1:0] = size;
        write_reg(REG_BASE, base);
        write_reg(REG_SIZE, size_word);
        cur_base = base;
        cur_size = size;
    endtask

    task automatic send_range(input logic act, input logic [ADDR_W-1:0] b,
                              input logic [ADDR_W-1:0] e);
        if (!steady_send && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < 40);
        end
        i_valid         <= 1'b1;
        i_action        <= act;
        i_begin_address <= b;
        i_end_address   <= e;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int count, input int steady_len, input int hold_at);
        int unsigned       eff, span, win_lo, off, avail, len, kind;
        logic [ADDR_W-1:0] b, e;
        logic              act;
        eff = (cur_size > MAX_BYTES_DEF) ? MAX_BYTES_DEF : cur_size;
        span = (eff > 256 && $urandom_range(3) != 0) ? 256 : eff;
        win_lo = (span < eff) ? $urandom_range(eff - span) : 0;
        steady_send = (steady_len > 0);
        steady_take = (steady_len > 0);
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            act = ($urandom_range(1) == 0) ? ACT_MARK : ACT_QUERY;
            if (eff == 0 || kind < 8) begin
                b = $urandom;
                case ($urandom_range(3))
                    0: begin
                        e = $urandom;
                    end
                    1: begin
                        e = b;
                    end
                    2: begin
                        e = b - $urandom_range(1, 64);
                    end
                    default: begin
                        e = b + $urandom_range(1, 64);
                    end
                endcase
            end else if (kind < 18) begin
                if ($urandom_range(1) == 0) begin
                    b = cur_base - $urandom_range(1, 8);
                    e = cur_base + $urandom_range(1, eff);
                end else begin
                    b = cur_base + $urandom_range(eff - 1);
                    e = cur_base + eff + $urandom_range(1, 8);
                end
            end else begin
                off = win_lo + $urandom_range(span - 1);
                avail = eff - off;
                if (kind < 22)
                    len = avail;
                else if (kind < 28 || avail < 24)
                    len = $urandom_range(1, avail);
                else
                    len = $urandom_range(1, 24);
                b = cur_base + off;
                e = b + len;
            end
            if (n == steady_len) begin
                steady_send = 1'b0;
                steady_take = 1'b0;
            end
            if (n == hold_at)
                hold_request = 1'b1;
            send_range(act, b, e);
        end
        steady_send = 1'b0;
        steady_take = 1'b0;
    endtask

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_object(32'h0000_0000, 13'd4096);
        send_range(ACT_QUERY, 32'd0, 32'd0);
        send_range(ACT_MARK, 32'd5, 32'd5);
        send_range(ACT_QUERY, 32'hffff_ffff, 32'd0);
        send_range(ACT_MARK, 32'hffff_ffff, 32'd0);
        send_range(ACT_QUERY, 32'd10, 32'd9);
        send_range(ACT_QUERY, 32'd0, 32'd8);
        send_range(ACT_QUERY, 32'd0, 32'd4096);
        send_range(ACT_MARK, 32'd0, 32'hffff_ffff);
        send_range(ACT_QUERY, 32'd4095, 32'd4097);
        send_range(ACT_QUERY, 32'h8000_0000, 32'hffff_ffff);
        send_range(ACT_MARK, 32'd3, 32'd5);
        send_range(ACT_QUERY, 32'd3, 32'd5);
        send_range(ACT_QUERY, 32'd2, 32'd5);
        send_range(ACT_QUERY, 32'd3, 32'd6);
        send_range(ACT_MARK, 32'd6, 32'd21);
        send_range(ACT_QUERY, 32'd3, 32'd21);
        send_range(ACT_MARK, 32'd5, 32'd6);
        send_range(ACT_QUERY, 32'd3, 32'd21);
        send_range(ACT_MARK, 32'd4088, 32'd4096);
        send_range(ACT_QUERY, 32'd4090, 32'd4096);
        send_range(ACT_MARK, 32'd3072, 32'd4096);
        send_range(ACT_QUERY, 32'd3000, 32'd4096);

        run_random_phase(200, 60, 120);
        set_object(32'hffff_f000, 13'd4096);
        run_random_phase(150, 0, -1);
        set_object(32'h0000_1000, 13'h1fff);
        run_random_phase(150, 0, -1);
        set_object($urandom, 13'd64);
        run_random_phase(120, 0, -1);
        set_object(32'hffff_ffff, 13'd0);
        run_random_phase(40, 0, -1);
        set_object(32'hffff_ffff, 13'd1);
        run_random_phase(30, 0, -1);
        set_object(32'h0000_0000, 13'd8);
        run_random_phase(100, 0, -1);
        set_object($urandom, SIZE_W'($urandom));
        run_random_phase(150, 0, -1);

        set_object(32'h0000_0000, 13'd4096);
        send_range(ACT_MARK, 32'd0, 32'd4096);
        send_range(ACT_QUERY, 32'd0, 32'd4096);
        send_range(ACT_QUERY, 32'd0, 32'd1);
        i_valid <= 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
